// ----- hw/rtl/adk_pkg.sv -----
`default_nettype none

package adk_pkg;

  localparam int IDLE_AVERAGE_COUNT = 100;
  localparam int NUM_KEYS           = 6;
  localparam int LEVEL_COUNT        = 6;

  localparam int MV_W       = 12;
  localparam int TOL_W      = 10;
  localparam int TICK_W     = 10;
  localparam int MS_W       = 16;
  localparam int KEY_W      = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFS_W      = 13;
  localparam int DIFF_W     = 15;

  localparam int CNT_W     = $clog2(IDLE_AVERAGE_COUNT + 1);
  localparam int SUM_W     = $clog2(IDLE_AVERAGE_COUNT * ((1 << MV_W) - 1) + 1);
  localparam int DIV_SHIFT = SUM_W + 7;
  localparam int RECIP     = ((1 << DIV_SHIFT) + IDLE_AVERAGE_COUNT - 1) / IDLE_AVERAGE_COUNT;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam int KQ_DEPTH = 2;
  localparam int KQ_PTR_W = $clog2(KQ_DEPTH);
  localparam int KQ_CNT_W = $clog2(KQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [KEY_W-1:0] KEY_NONE     = 3'd0;
  localparam logic [KEY_W-1:0] NO_PRESS_KEY = 3'd6;

  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] EV_SHORT   = 2'd2;
  localparam logic [KIND_W-1:0] EV_LONG    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_NOM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 3'd6;

  localparam logic [MV_W-1:0]   RST_IDLE_LOW    = 12'd2080;
  localparam logic [MV_W-1:0]   RST_IDLE_HIGH   = 12'd2400;
  localparam logic [MV_W-1:0]   RST_IDLE_NOM    = 12'd2221;
  localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 10'd50;
  localparam logic [TICK_W-1:0] RST_TICK        = 10'd30;
  localparam logic [MS_W-1:0]   RST_SHORT_LIMIT = 16'd800;
  localparam logic [MS_W-1:0]   RST_LONG_LIMIT  = 16'd1000;

  localparam logic [MV_W-1:0] KEY_LEVEL [LEVEL_COUNT] = '{
    12'd189, 12'd521, 12'd827, 12'd1126, 12'd1437, 12'd1746
  };

  typedef struct packed {
    logic [MV_W-1:0]   idle_low_mv;
    logic [MV_W-1:0]   idle_high_mv;
    logic [MV_W-1:0]   idle_nominal_mv;
    logic [TOL_W-1:0]  match_tolerance_mv;
    logic [TICK_W-1:0] tick_ms;
    logic [MS_W-1:0]   short_limit_ms;
    logic [MS_W-1:0]   long_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/adk_front.sv -----
`default_nettype none

module adk_front import adk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  output logic             full,
  input  logic [MV_W-1:0]  sample_mv,
  input  logic             kq_full,
  output logic             kq_push,
  output logic [KEY_W-1:0] kq_key
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUB  = 2'd2;

  logic [1:0]              state;
  logic [SUM_W-1:0]        idle_sum;
  logic [CNT_W-1:0]        idle_count;
  logic signed [OFS_W-1:0] level_offset;
  logic [SUM_W-1:0]        div_sum;
  logic [PROD_W-1:0]       div_prod;

  logic                     accept;
  logic                     is_idle;
  logic [CNT_W-1:0]         count_inc;
  logic [SUM_W-1:0]         sum_inc;
  logic                     block_done;
  logic [MV_W-1:0]          avg;
  logic signed [OFS_W-1:0]  offset_next;
  logic signed [DIFF_W-1:0] ofs_x;
  logic signed [DIFF_W-1:0] tol_s;
  logic signed [DIFF_W-1:0] diff [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0]   win;
  logic [KEY_W-1:0]         hit;

  assign full       = (state != ST_IDLE) || kq_full;
  assign accept     = push && !full;
  assign is_idle    = (sample_mv >= cfg.idle_low_mv) && (sample_mv <= cfg.idle_high_mv);
  assign count_inc  = idle_count + CNT_W'(1);
  assign sum_inc    = idle_sum + SUM_W'(sample_mv);
  assign block_done = (count_inc == CNT_W'(IDLE_AVERAGE_COUNT));
  assign avg        = div_prod[DIV_SHIFT +: MV_W];
  assign offset_next = $signed({1'b0, avg}) - $signed({1'b0, cfg.idle_nominal_mv});
  assign ofs_x      = DIFF_W'(level_offset);
  assign tol_s      = $signed({{(DIFF_W-TOL_W){1'b0}}, cfg.match_tolerance_mv});

  always_comb begin
    for (int k = 0; k < LEVEL_COUNT; k++) begin
      diff[k] = $signed({{(DIFF_W-MV_W){1'b0}}, sample_mv})
              - $signed({{(DIFF_W-MV_W){1'b0}}, KEY_LEVEL[k]}) - ofs_x;
      win[k]  = (diff[k] >= -tol_s) && (diff[k] <= tol_s);
    end
  end

  // lowest matching key wins
  always_comb begin
    hit = KEY_NONE;
    for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
      if (k < NUM_KEYS && win[k]) begin
        hit = KEY_W'(k + 1);
      end
    end
  end

  assign kq_push = accept && (is_idle || (hit != KEY_NONE));
  assign kq_key  = is_idle ? KEY_NONE : hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idle_sum     <= '0;
      idle_count   <= '0;
      level_offset <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && is_idle) begin
            if (block_done) begin
              idle_sum   <= '0;
              idle_count <= '0;
              state      <= ST_MUL;
            end else begin
              idle_sum   <= sum_inc;
              idle_count <= count_inc;
            end
          end
        end
        ST_MUL: state <= ST_SUB;
        ST_SUB: begin
          level_offset <= offset_next;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // block average by reciprocal multiply
  always_ff @(posedge clk) begin
    if (accept && is_idle && block_done) begin
      div_sum <= sum_inc;
    end
    if (state == ST_MUL) begin
      div_prod <= PROD_W'(div_sum) * PROD_W'(RECIP_W'(RECIP));
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adk_key_queue.sv -----
`default_nettype none

module adk_key_queue import adk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [KEY_W-1:0] push_key,
  output logic             full,
  output logic             valid,
  output logic [KEY_W-1:0] key,
  input  logic             pop
);

  logic [KEY_W-1:0]    mem [KQ_DEPTH];
  logic [KQ_PTR_W-1:0] wr_ptr;
  logic [KQ_PTR_W-1:0] rd_ptr;
  logic [KQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == KQ_CNT_W'(KQ_DEPTH));
  assign valid   = (count != '0);
  assign key     = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + KQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + KQ_PTR_W'(1);
      end
      count <= count + KQ_CNT_W'(do_push) - KQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_key;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adk_back.sv -----
`default_nettype none

module adk_back import adk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              kq_valid,
  input  logic [KEY_W-1:0]  kq_key,
  output logic              kq_pop,
  input  logic              pop,
  output logic              empty,
  output logic [KEY_W-1:0]  key_index,
  output logic [KIND_W-1:0] event_kind,
  output logic              last_event
);

  logic [KEY_W-1:0] previous_key;
  logic [MS_W-1:0]  hold_time_ms;
  logic             long_reported;

  res_t                rq [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;

  logic [MS_W:0]       hold_sum;
  logic [MS_W-1:0]     hold_sat;
  logic [MS_W-1:0]     hold_time_next;
  logic [KEY_W-1:0]    previous_key_next;
  logic                long_reported_next;
  logic [1:0]          n_ev;
  res_t                ev0;
  res_t                ev1;
  logic                do_pop;
  logic [RQ_PTR_W-1:0] wr_ptr_1;

  assign kq_pop   = kq_valid && (count <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign do_pop   = pop && !empty;
  assign empty    = (count == '0);
  assign key_index  = rq[rd_ptr].key;
  assign event_kind = rq[rd_ptr].kind;
  assign last_event = rq[rd_ptr].last;
  assign hold_sum = {1'b0, hold_time_ms} + (MS_W+1)'(cfg.tick_ms);
  assign hold_sat = hold_sum[MS_W] ? '1 : hold_sum[MS_W-1:0];
  assign wr_ptr_1 = wr_ptr + RQ_PTR_W'(1);

  always_comb begin
    hold_time_next     = hold_sat;
    previous_key_next  = previous_key;
    long_reported_next = long_reported;
    n_ev               = 2'd0;
    ev0                = '{key: previous_key, kind: EV_LONG, last: 1'b1};
    ev1                = '{key: previous_key, kind: EV_LONG, last: 1'b1};
    if (kq_key == previous_key) begin
      if (kq_key != KEY_NONE && hold_sat >= cfg.long_limit_ms && !long_reported) begin
        n_ev               = 2'd1;
        long_reported_next = 1'b1;
      end
    end else begin
      if (kq_key == KEY_NONE) begin
        ev0.kind = EV_RELEASE;
        n_ev     = 2'd1;
        if (hold_sat <= cfg.short_limit_ms) begin
          ev1.kind = EV_SHORT;
          n_ev     = 2'd2;
        end else if (hold_sat >= cfg.long_limit_ms && !long_reported) begin
          ev1.kind = EV_LONG;
          n_ev     = 2'd2;
        end
        long_reported_next = 1'b0;
      end else if (kq_key != NO_PRESS_KEY) begin
        ev0.key  = kq_key;
        ev0.kind = EV_PRESS;
        n_ev     = 2'd1;
      end
      hold_time_next    = '0;
      previous_key_next = kq_key;
    end
    ev0.last = (n_ev == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key  <= KEY_NONE;
      hold_time_ms  <= '0;
      long_reported <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (kq_pop) begin
        previous_key  <= previous_key_next;
        hold_time_ms  <= hold_time_next;
        long_reported <= long_reported_next;
        wr_ptr        <= wr_ptr + RQ_PTR_W'(n_ev);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      count <= count + (kq_pop ? RQ_CNT_W'(n_ev) : '0) - RQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (kq_pop && n_ev != 2'd0) begin
      rq[wr_ptr] <= ev0;
    end
    if (kq_pop && n_ev == 2'd2) begin
      rq[wr_ptr_1] <= ev1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adc_ladder_key_decoder.sv -----
`default_nettype none

// Resistor-ladder keypad decoder. Push one ADC sample (mV) per transaction; idle-window
// samples are averaged in blocks of 100 to track a level offset, other samples are matched
// to keys 1..6, and press, release, short-tap and long-press events come out of the result
// queue, one per pop, with last_event set on the final event of a sample. Unmatched samples
// are dropped silently. A sample is taken every cycle while results are drained; full also
// rises when undrained results fill the internal queues, and the sample that completes a
// block of idle samples keeps full high while the block average goes through the
// reciprocal multiplier and the offset subtract. Results are registered in the key queue
// and then the result queue and drain one per cycle, so a sample that makes two events
// fills two result queue entries. Configuration is written through cfg_valid, cfg_index
// and cfg_data, which is always ready; write it only while the block is quiet.
module adc_ladder_key_decoder import adk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [MV_W-1:0]       sample_mv,
  output logic                  empty,
  input  logic                  pop,
  output logic [KEY_W-1:0]      key_index,
  output logic [KIND_W-1:0]     event_kind,
  output logic                  last_event,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             kq_push;
  logic [KEY_W-1:0] kq_push_key;
  logic             kq_full;
  logic             kq_valid;
  logic [KEY_W-1:0] kq_key;
  logic             kq_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_low_mv        <= RST_IDLE_LOW;
      cfg.idle_high_mv       <= RST_IDLE_HIGH;
      cfg.idle_nominal_mv    <= RST_IDLE_NOM;
      cfg.match_tolerance_mv <= RST_TOLERANCE;
      cfg.tick_ms            <= RST_TICK;
      cfg.short_limit_ms     <= RST_SHORT_LIMIT;
      cfg.long_limit_ms      <= RST_LONG_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDLE_LOW:    cfg.idle_low_mv        <= cfg_data[MV_W-1:0];
        CFG_IDLE_HIGH:   cfg.idle_high_mv       <= cfg_data[MV_W-1:0];
        CFG_IDLE_NOM:    cfg.idle_nominal_mv    <= cfg_data[MV_W-1:0];
        CFG_TOLERANCE:   cfg.match_tolerance_mv <= cfg_data[TOL_W-1:0];
        CFG_TICK:        cfg.tick_ms            <= cfg_data[TICK_W-1:0];
        CFG_SHORT_LIMIT: cfg.short_limit_ms     <= cfg_data[MS_W-1:0];
        CFG_LONG_LIMIT:  cfg.long_limit_ms      <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  adk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .sample_mv (sample_mv),
    .kq_full   (kq_full),
    .kq_push   (kq_push),
    .kq_key    (kq_push_key)
  );

  adk_key_queue u_key_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (kq_push),
    .push_key (kq_push_key),
    .full     (kq_full),
    .valid    (kq_valid),
    .key      (kq_key),
    .pop      (kq_pop)
  );

  adk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .kq_valid   (kq_valid),
    .kq_key     (kq_key),
    .kq_pop     (kq_pop),
    .pop        (pop),
    .empty      (empty),
    .key_index  (key_index),
    .event_kind (event_kind),
    .last_event (last_event)
  );

endmodule

`default_nettype wire
